// File: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the fixed-point sine series core:
// controller states, command and status bundles, datapath widths.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int ANGLE_W     = 32;
    localparam int TOL_W       = 29;
    localparam int TERMS_W     = 5;
    localparam int OUT_DATA_W  = 40;     // 32 + 5 + 1 + 1, padded to bytes
    localparam int WORD_W      = 64;     // term magnitude, sum, x^2
    localparam int HALF_W      = 32;     // multiplier chunk width
    localparam int PROD_W      = 128;    // full product of two words
    localparam int MUL_STEPS   = 4;      // partial products per multiply
    localparam int DIV_BITS    = 4;      // quotient bits per divide cycle
    localparam int DIV_STEPS   = WORD_W / DIV_BITS;

    localparam logic [TOL_W-1:0]         TOL_RESET = 29'd2684;
    localparam logic [WORD_W-1:0]        TERM_CAP  = 64'h2000_0000_0000_0000;
    localparam logic signed [WORD_W-1:0] SUM_CAP   = 64'sh4000_0000_0000_0000;
    localparam logic signed [WORD_W-1:0] OUT_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] OUT_MIN   = -64'sh0000_0000_8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_SAVE,
        ST_ADD,
        ST_TERM_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_NEXT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;       // take new angle, start x*x
        logic mul_run;    // advance the multiplier
        logic sq_save;    // store x^2
        logic add_term;   // accumulate current term, check stop
        logic mul_term;   // start term * x^2
        logic div_start;  // start divide by (n-1)n
        logic div_run;    // advance the divider
        logic div_save;   // quotient becomes next term, count up
        logic out_load;   // capture final result
    } t_cmd;

    typedef struct packed {
        logic mul_last;
        logic div_last;
        logic tol_hit;
        logic cap_hit;
    } t_sts;

endpackage

// File: src/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer for the series loop: steps the shared multiplier and divider,
// decides when to stop, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sts_pkg::t_sts i_sts,
    output sts_pkg::t_cmd o_cmd,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready
);

    sts_pkg::t_state r_state;
    sts_pkg::t_state n_state;
    logic            r_out_valid;
    logic            stop;

    assign stop = i_sts.tol_hit || i_sts.cap_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sts_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sts_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sts_pkg::ST_SQ_MUL;
            end
            sts_pkg::ST_SQ_MUL: begin
                if (i_sts.mul_last) n_state = sts_pkg::ST_SQ_SAVE;
            end
            sts_pkg::ST_SQ_SAVE:   n_state = sts_pkg::ST_ADD;
            sts_pkg::ST_ADD: begin
                n_state = stop ? sts_pkg::ST_FINISH : sts_pkg::ST_TERM_MUL;
            end
            sts_pkg::ST_TERM_MUL: begin
                if (i_sts.mul_last) n_state = sts_pkg::ST_DIV_START;
            end
            sts_pkg::ST_DIV_START: n_state = sts_pkg::ST_DIV;
            sts_pkg::ST_DIV: begin
                if (i_sts.div_last) n_state = sts_pkg::ST_NEXT;
            end
            sts_pkg::ST_NEXT:      n_state = sts_pkg::ST_ADD;
            sts_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) n_state = sts_pkg::ST_IDLE;
            end
            default:               n_state = sts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sts_pkg::ST_SQ_MUL:    o_cmd.mul_run = 1'b1;
            sts_pkg::ST_SQ_SAVE:   o_cmd.sq_save = 1'b1;
            sts_pkg::ST_ADD: begin
                o_cmd.add_term = 1'b1;
                o_cmd.mul_term = !stop;
            end
            sts_pkg::ST_TERM_MUL:  o_cmd.mul_run = 1'b1;
            sts_pkg::ST_DIV_START: o_cmd.div_start = 1'b1;
            sts_pkg::ST_DIV:       o_cmd.div_run = 1'b1;
            sts_pkg::ST_NEXT:      o_cmd.div_save = 1'b1;
            sts_pkg::ST_FINISH:    o_cmd.out_load = !r_out_valid || i_out_ready;
            default:               o_cmd = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while still pending");

    // accepted item starts the x*x multiply next cycle
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == sts_pkg::ST_SQ_MUL))
        else $error("accepted item did not start");

    // finished item holds while the output side stalls
    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sts_pkg::ST_FINISH && r_out_valid && !i_out_ready)
        |=> (r_state == sts_pkg::ST_FINISH))
        else $error("finished item dropped during stall");

endmodule

// File: src/sts_datapath.sv
// ----------------------------------------------------------------------------
// sts_datapath
// Term, x^2 and sum registers with a shared 32x32 multiplier that builds a
// 64x64 product over four partial products, and a 4-bit-per-cycle divider
// by the small constant (n-1)n.
// ----------------------------------------------------------------------------
module sts_datapath #(
    parameter int MAX_TERMS = 24,
    parameter int FRAC_BITS = 28
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sts_pkg::t_cmd                  i_cmd,
    output sts_pkg::t_sts                  o_sts,
    input  logic [sts_pkg::ANGLE_W-1:0]    i_angle,
    input  logic                           i_cfg_wr_en,
    input  logic [sts_pkg::TOL_W-1:0]      i_cfg_wr_data,
    output logic [sts_pkg::OUT_DATA_W-1:0] o_out_data
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    // largest divisor: 2i(2i+1) with i = MAX_TERMS-1
    localparam int DW    = $clog2((2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1) + 1);
    localparam int W     = sts_pkg::WORD_W;
    localparam int H     = sts_pkg::HALF_W;
    localparam int DSW   = $clog2(sts_pkg::DIV_STEPS);

    logic [sts_pkg::TOL_W-1:0]   r_tol;
    logic                        r_neg;
    logic [W-1:0]                r_x2;
    logic [W-1:0]                r_mag;
    logic signed [W-1:0]         r_acc;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_cap;

    logic [W-1:0]                r_ma;
    logic [W-1:0]                r_mb;
    logic [2:0]                  r_mstep;
    logic [1:0]                  r_pshift;
    logic [W-1:0]                r_pp;
    logic [sts_pkg::PROD_W-1:0]  r_prod;

    logic [DW:0]                 r_rem;
    logic [W-1:0]                r_quo;
    logic [DW-1:0]               r_dvs;
    logic [DSW-1:0]              r_dstep;

    logic [sts_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [sts_pkg::ANGLE_W-1:0] ax;
    logic [H-1:0]                a_chunk;
    logic [H-1:0]                b_chunk;
    logic [sts_pkg::PROD_W-1:0]  pp_shifted;
    logic                        prod_hi_nz;
    logic [W-1:0]                prod_mid;
    logic [W-1:0]                mulsh;
    logic [DW:0]                 rem_t;
    logic [W-1:0]                quo_t;
    logic [DW-1:0]               two_i;
    logic [DW-1:0]               dvs_next;
    logic signed [W-1:0]         term_s;
    logic signed [W-1:0]         sum;
    logic signed [W-1:0]         sum_clamped;
    logic signed [W-1:0]         acc_f;
    logic [sts_pkg::ANGLE_W-1:0] sine;
    logic                        sat;
    logic [CNT_W+4:0]            cnt_ext;

    assign ax = i_angle[sts_pkg::ANGLE_W-1] ? (~i_angle + 1'b1) : i_angle;

    // multiplier: partial product k uses a chunk k[1], b chunk k[0]
    assign a_chunk    = r_mstep[1] ? r_ma[W-1:H] : r_ma[H-1:0];
    assign b_chunk    = r_mstep[0] ? r_mb[W-1:H] : r_mb[H-1:0];
    assign pp_shifted = {{W{1'b0}}, r_pp} << {r_pshift, 5'b0};

    // (a*b) >> FRAC_BITS, saturated at 2^61
    assign prod_hi_nz = |(r_prod >> (FRAC_BITS + W));
    assign prod_mid   = r_prod[FRAC_BITS +: W];
    assign mulsh      = (prod_hi_nz || prod_mid > sts_pkg::TERM_CAP) ?
                        sts_pkg::TERM_CAP : prod_mid;

    assign two_i    = DW'({r_cnt, 1'b0});
    assign dvs_next = two_i * (two_i + 1'b1);

    always_comb begin
        rem_t = r_rem;
        quo_t = r_quo;
        for (int k = 0; k < sts_pkg::DIV_BITS; k++) begin
            rem_t = {rem_t[DW-1:0], quo_t[W-1]};
            quo_t = {quo_t[W-2:0], 1'b0};
            if (rem_t >= {1'b0, r_dvs}) begin
                rem_t    = rem_t - {1'b0, r_dvs};
                quo_t[0] = 1'b1;
            end
        end
    end

    // odd term index adds, even subtracts; sum clamps at +-2^62
    assign term_s = $signed(r_mag);
    assign sum    = r_cnt[0] ? (r_acc + term_s) : (r_acc - term_s);
    always_comb begin
        if (sum > sts_pkg::SUM_CAP) begin
            sum_clamped = sts_pkg::SUM_CAP;
        end else if (sum < -sts_pkg::SUM_CAP) begin
            sum_clamped = -sts_pkg::SUM_CAP;
        end else begin
            sum_clamped = sum;
        end
    end

    assign acc_f = r_neg ? -r_acc : r_acc;
    always_comb begin
        if (acc_f > sts_pkg::OUT_MAX) begin
            sine = sts_pkg::OUT_MAX[sts_pkg::ANGLE_W-1:0];
            sat  = 1'b1;
        end else if (acc_f < sts_pkg::OUT_MIN) begin
            sine = sts_pkg::OUT_MIN[sts_pkg::ANGLE_W-1:0];
            sat  = 1'b1;
        end else begin
            sine = acc_f[sts_pkg::ANGLE_W-1:0];
            sat  = 1'b0;
        end
    end

    assign cnt_ext = {5'b0, r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sts_pkg::TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= i_angle[sts_pkg::ANGLE_W-1];
            r_mag   <= {{(W - sts_pkg::ANGLE_W){1'b0}}, ax};
            r_acc   <= '0;
            r_cnt   <= CNT_W'(1);
            r_cap   <= 1'b0;
            r_ma    <= {{(W - sts_pkg::ANGLE_W){1'b0}}, ax};
            r_mb    <= {{(W - sts_pkg::ANGLE_W){1'b0}}, ax};
            r_mstep <= '0;
            r_prod  <= '0;
        end
        if (i_cmd.mul_term) begin
            r_ma    <= r_mag;
            r_mb    <= r_x2;
            r_mstep <= '0;
            r_prod  <= '0;
        end
        if (i_cmd.mul_run) begin
            if (r_mstep < 3'(sts_pkg::MUL_STEPS)) begin
                r_pp     <= a_chunk * b_chunk;
                r_pshift <= {1'b0, r_mstep[1]} + {1'b0, r_mstep[0]};
            end
            if (r_mstep != 3'd0) begin
                r_prod <= r_prod + pp_shifted;
            end
            r_mstep <= r_mstep + 3'd1;
        end
        if (i_cmd.sq_save) begin
            r_x2 <= mulsh;
        end
        if (i_cmd.add_term) begin
            r_acc <= sum_clamped;
            r_cap <= !o_sts.tol_hit && o_sts.cap_hit;
        end
        if (i_cmd.div_start) begin
            r_quo   <= mulsh;
            r_rem   <= '0;
            r_dvs   <= dvs_next;
            r_dstep <= '0;
        end
        if (i_cmd.div_run) begin
            r_quo   <= quo_t;
            r_rem   <= rem_t;
            r_dstep <= r_dstep + 1'b1;
        end
        if (i_cmd.div_save) begin
            r_mag <= r_quo;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {1'b0, sat, r_cap, cnt_ext[sts_pkg::TERMS_W-1:0], sine};
        end
    end

    assign o_sts.mul_last = (r_mstep == 3'(sts_pkg::MUL_STEPS));
    assign o_sts.div_last = (r_dstep == DSW'(sts_pkg::DIV_STEPS - 1));
    assign o_sts.tol_hit  = (r_mag <= {{(W - sts_pkg::TOL_W){1'b0}}, r_tol});
    assign o_sts.cap_hit  = (r_cnt >= CNT_W'(MAX_TERMS));
    assign o_out_data     = r_out_data;

    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_run |-> (r_rem < {1'b0, r_dvs}))
        else $error("divider remainder not below divisor");

    a_term_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_term |-> (r_mag <= sts_pkg::TERM_CAP))
        else $error("term magnitude above saturation cap");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_term |-> (r_cnt != '0 && r_cnt <= CNT_W'(MAX_TERMS)))
        else $error("term count out of range");

endmodule

// File: src/sine_taylor_series_tolerance_core.sv
// ----------------------------------------------------------------------------
// sine_taylor_series_tolerance_core
// sin(x) by its Maclaurin series in fixed point, with a programmable stop
// tolerance on the term magnitude and a cap on the number of terms.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one angle (signed Q3.28) per item in s_axis_tdata.
//   Master stream: sine_value, terms_used, cap_reached, saturated.
//   i_cfg_wr_en/i_cfg_wr_data write the tolerance (Q1.28); write it only
//   while the core is idle.
// Datapath: one item runs alone through a shared multiplier (4 partial
//   products per multiply) and a divider that retires 4 quotient bits a
//   cycle. T, the number of terms added, is at most MAX_TERMS and is set
//   by the tolerance and the angle.
// Input: a new angle is taken only while the sequencer is idle, once the
//   previous item has been moved to the output register.
// Stall: a finished result sits in the output register; the core accepts
//   the next angle meanwhile and holds its own finished result until the
//   register is taken.
// Reset: synchronous, active low; clears the sequencer and the valid flag
//   and sets the tolerance to 2684.
// ----------------------------------------------------------------------------
module sine_taylor_series_tolerance_core #(
    parameter int MAX_TERMS = 24,
    parameter int FRAC_BITS = 28
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sts_pkg::ANGLE_W-1:0]    s_axis_tdata,   // [31:0] angle
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] sine_value, [36:32] terms_used, [37] cap_reached,
    // [38] saturated, [39] zero
    output logic [sts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [sts_pkg::TOL_W-1:0]      i_cfg_wr_data
);

    sts_pkg::t_cmd cmd;
    sts_pkg::t_sts sts;

    sts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    sts_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_angle       (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_data    (m_axis_tdata)
    );

endmodule
